### hw/rtl/c64spp_pkg.sv
package c64spp_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_ONE   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MULTI_TWO   = 8'd3;

	localparam logic [1:0] MODE_MONO  = 2'd0;
	localparam logic [1:0] MODE_FIXED = 2'd1;
	localparam logic [1:0] MODE_AUTO  = 2'd2;

	localparam logic [1:0] CODE_TRANSPARENT = 2'b00;
	localparam logic [1:0] CODE_MULTI_ONE   = 2'b01;
	localparam logic [1:0] CODE_MULTI_TWO   = 2'b11;
	localparam logic [1:0] CODE_OTHER       = 2'b10;

	localparam logic [7:0] META_MONO  = 8'h00;
	localparam logic [7:0] META_MULTI = 8'h80;

	localparam int PIX_PER_ROW_MONO  = 24;
	localparam int PIX_PER_ROW_MULTI = 12;

	localparam int         SLOT_W             = 3;
	localparam logic [2:0] PIX_PER_BYTE_MULTI = 3'd4;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = 2;
	localparam int FIFO_CNT_W = 3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] transparent_index;
		logic [7:0] multi_one_index;
		logic [7:0] multi_two_index;
	} cfg_t;

	typedef struct packed {
		logic [7:0] sprite_byte;
		logic       sprite_end;
		logic       too_many_colors;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

### hw/rtl/c64spp_if.sv
interface c64spp_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_index;

	modport source (output valid, output pixel_index, input ready);
	modport sink (input valid, input pixel_index, output ready);
endinterface

interface c64spp_sprite_if;
	logic       valid;
	logic       ready;
	logic [7:0] sprite_byte;
	logic       sprite_end;
	logic       too_many_colors;

	modport source (output valid, output sprite_byte, output sprite_end,
		output too_many_colors, input ready);
	modport sink (input valid, input sprite_byte, input sprite_end,
		input too_many_colors, output ready);
endinterface

interface c64spp_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [c64spp_pkg::CFG_IDX_W-1:0]  index;
	logic [c64spp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/c64spp_encoder.sv
module c64spp_encoder #(
	parameter int SPRITE_ROWS = 21,
	parameter int COLOR_SLOTS = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         pixel_index,
	input  c64spp_pkg::cfg_t   cfg,
	output c64spp_pkg::push_t  push
);

	localparam int CW = $clog2(c64spp_pkg::PIX_PER_ROW_MONO * SPRITE_ROWS + 1);
	localparam int UW = $clog2(COLOR_SLOTS + 1);
	localparam int IW = $clog2(COLOR_SLOTS);
	localparam logic [CW-1:0] TOTAL_MONO  = CW'(c64spp_pkg::PIX_PER_ROW_MONO * SPRITE_ROWS);
	localparam logic [CW-1:0] TOTAL_MULTI = CW'(c64spp_pkg::PIX_PER_ROW_MULTI * SPRITE_ROWS);
	localparam logic [UW-1:0] SLOTS       = UW'(COLOR_SLOTS);

	logic [c64spp_pkg::SLOT_W-1:0] slot_q;
	logic [7:0]                    acc_q;
	logic [CW-1:0]                 cnt_q;
	logic [7:0]                    table_q [COLOR_SLOTS];
	logic [UW-1:0]                 used_q;
	logic                          ovf_q;

	logic                          mono;
	logic [COLOR_SLOTS-1:0]        hit;
	logic [1:0]                    hit_idx;
	logic                          add_color;
	logic                          ovf_now;
	logic [1:0]                    code;
	logic [7:0]                    acc_next;
	logic [c64spp_pkg::SLOT_W-1:0] slot_next;
	logic [CW-1:0]                 cnt_next;
	logic                          done;
	logic                          full;
	logic                          emit_data;
	logic                          ovf_next;
	c64spp_pkg::result_t           data_res;
	c64spp_pkg::result_t           meta_res;

	assign mono = (cfg.mode == c64spp_pkg::MODE_MONO);

	always_comb begin
		hit_idx = 2'd0;
		for (int i = COLOR_SLOTS - 1; i >= 0; i--) begin
			hit[i] = (UW'(i) < used_q) && (table_q[i] == pixel_index);
			if (hit[i]) begin
				hit_idx = 2'(i);
			end
		end
	end

	always_comb begin
		add_color = 1'b0;
		ovf_now   = 1'b0;
		code      = c64spp_pkg::CODE_TRANSPARENT;
		case (cfg.mode)
			c64spp_pkg::MODE_MONO: begin
				code = {1'b0, pixel_index != cfg.transparent_index};
			end
			c64spp_pkg::MODE_FIXED: begin
				if (pixel_index == cfg.transparent_index) begin
					code = c64spp_pkg::CODE_TRANSPARENT;
				end else if (pixel_index == cfg.multi_one_index) begin
					code = c64spp_pkg::CODE_MULTI_ONE;
				end else if (pixel_index == cfg.multi_two_index) begin
					code = c64spp_pkg::CODE_MULTI_TWO;
				end else begin
					code = c64spp_pkg::CODE_OTHER;
				end
			end
			default: begin
				// auto mode, also taken for the unused mode code
				if (|hit) begin
					code = hit_idx;
				end else if (used_q < SLOTS) begin
					code      = 2'(used_q);
					add_color = 1'b1;
				end else begin
					code    = c64spp_pkg::CODE_TRANSPARENT;
					ovf_now = 1'b1;
				end
			end
		endcase
	end

	always_comb begin
		acc_next  = mono ? {acc_q[6:0], code[0]} : {acc_q[5:0], code};
		slot_next = slot_q + 3'd1;
		cnt_next  = cnt_q + CW'(1);
		done      = cnt_next >= (mono ? TOTAL_MONO : TOTAL_MULTI);
		full      = mono ? (slot_next == '0) : (slot_next >= c64spp_pkg::PIX_PER_BYTE_MULTI);
		emit_data = full || (done && (slot_next != '0));
		ovf_next  = ovf_q | ovf_now;

		data_res.sprite_byte     = acc_next;
		data_res.sprite_end      = 1'b0;
		data_res.too_many_colors = 1'b0;
		meta_res.sprite_byte     = mono ? c64spp_pkg::META_MONO : c64spp_pkg::META_MULTI;
		meta_res.sprite_end      = 1'b1;
		meta_res.too_many_colors = ovf_next;

		push.first  = emit_data ? data_res : meta_res;
		push.second = meta_res;
		push.n      = fire ? ({1'b0, emit_data} + {1'b0, done}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			acc_q  <= '0;
			cnt_q  <= '0;
			used_q <= '0;
			ovf_q  <= 1'b0;
		end else if (fire) begin
			if (done) begin
				slot_q <= '0;
				acc_q  <= '0;
				cnt_q  <= '0;
				used_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				slot_q <= emit_data ? '0 : slot_next;
				acc_q  <= emit_data ? '0 : acc_next;
				cnt_q  <= cnt_next;
				used_q <= used_q + UW'(add_color);
				ovf_q  <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && add_color) begin
			table_q[used_q[IW-1:0]] <= pixel_index;
		end
	end

endmodule

### hw/rtl/c64spp_result_fifo.sv
module c64spp_result_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  c64spp_pkg::push_t         push,
	output logic                      room,
	output logic                      valid,
	input  logic                      pop,
	output c64spp_pkg::result_t       head
);

	c64spp_pkg::result_t                 mem_q [c64spp_pkg::FIFO_DEPTH];
	logic [c64spp_pkg::FIFO_PTR_W-1:0]   wr_q;
	logic [c64spp_pkg::FIFO_PTR_W-1:0]   rd_q;
	logic [c64spp_pkg::FIFO_CNT_W-1:0]   cnt_q;
	logic                                pop_en;

	assign room   = cnt_q <= c64spp_pkg::FIFO_CNT_W'(c64spp_pkg::FIFO_DEPTH - 2);
	assign valid  = cnt_q != '0;
	assign pop_en = pop && valid;
	assign head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + 2'd1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.n;
			rd_q  <= rd_q + c64spp_pkg::FIFO_PTR_W'(pop_en);
			cnt_q <= cnt_q + c64spp_pkg::FIFO_CNT_W'(push.n)
				- c64spp_pkg::FIFO_CNT_W'(pop_en);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= c64spp_pkg::FIFO_CNT_W'(c64spp_pkg::FIFO_DEPTH))
		else $error("result fifo count above depth");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> ({1'b0, cnt_q} + {2'b0, push.n}
		<= 4'(c64spp_pkg::FIFO_DEPTH)))
		else $error("result fifo overrun");
	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		$past(pop_en) && ($past(push.n) == 2'd0) |-> cnt_q == $past(cnt_q) - 3'd1)
		else $error("result fifo lost or duplicated a beat");
`endif

endmodule

### hw/rtl/c64_sprite_pixel_packer.sv
// Packs a stream of palette-index pixels into C64 sprite data. Each accepted
// pixel beat is encoded in the cycle it arrives: mono packs 24 pixels per row,
// 8 per byte; multicolor packs 12 pixels per row, 4 two-bit codes per byte,
// first pixel in the top bits, with fixed or first-seen auto code assignment.
// After SPRITE_ROWS rows a closing byte ($00 mono, $80 multicolor) follows,
// flagged by sprite_end, with too_many_colors set when auto mode ran out of
// COLOR_SLOTS table entries. The block takes one pixel per clock; a pixel
// that closes a byte or a sprite yields one or two result beats, which wait
// in a four-entry result queue, so input stalls only when the output side
// holds back and fewer than two queue entries are free. Configuration writes
// are taken in any cycle and belong between sprites.
module c64_sprite_pixel_packer #(
	parameter int SPRITE_ROWS = 21,
	parameter int COLOR_SLOTS = 4
) (
	input logic            clk,
	input logic            arst_n,
	c64spp_pixel_if.sink   pix,
	c64spp_sprite_if.source spr,
	c64spp_cfg_if.sink     cfg
);

	c64spp_pkg::cfg_t    cfg_q;
	c64spp_pkg::push_t   push;
	c64spp_pkg::result_t head;
	logic                room;
	logic                fire;

	assign cfg.ready = 1'b1;
	assign pix.ready = room;
	assign fire      = pix.valid && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode              <= c64spp_pkg::MODE_MONO;
			cfg_q.transparent_index <= 8'd0;
			cfg_q.multi_one_index   <= 8'd1;
			cfg_q.multi_two_index   <= 8'd2;
		end else if (cfg.valid) begin
			case (cfg.index)
				c64spp_pkg::REG_MODE:        cfg_q.mode              <= cfg.data[1:0];
				c64spp_pkg::REG_TRANSPARENT: cfg_q.transparent_index <= cfg.data[7:0];
				c64spp_pkg::REG_MULTI_ONE:   cfg_q.multi_one_index   <= cfg.data[7:0];
				c64spp_pkg::REG_MULTI_TWO:   cfg_q.multi_two_index   <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	c64spp_encoder #(
		.SPRITE_ROWS(SPRITE_ROWS),
		.COLOR_SLOTS(COLOR_SLOTS)
	) u_encoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.pixel_index(pix.pixel_index),
		.cfg        (cfg_q),
		.push       (push)
	);

	c64spp_result_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.valid (spr.valid),
		.pop   (spr.ready),
		.head  (head)
	);

	assign spr.sprite_byte     = head.sprite_byte;
	assign spr.sprite_end      = head.sprite_end;
	assign spr.too_many_colors = head.too_many_colors;

endmodule

### tb/tb_c64_sprite_pixel_packer.sv
`timescale 1ns / 1ps

module tb_c64_sprite_pixel_packer;

	localparam int ROWS        = 21;
	localparam int SLOTS       = 4;
	localparam int ITEMS       = 950;
	localparam int SETTLE      = 16;
	localparam int QUIET_LIMIT = 2000;

	// mode value three behaves as auto multicolor
	localparam logic [1:0] MODE_AUTO_ALT = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	c64spp_pixel_if  pix ();
	c64spp_sprite_if spr ();
	c64spp_cfg_if    cfg ();

	logic                              pix_valid = 1'b0;
	logic [7:0]                        pix_data  = '0;
	logic                              spr_ready = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic [c64spp_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [c64spp_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	assign pix.valid       = pix_valid;
	assign pix.pixel_index = pix_data;
	assign spr.ready       = spr_ready;
	assign cfg.valid       = cfg_valid;
	assign cfg.index       = cfg_index;
	assign cfg.data        = cfg_data;

	c64_sprite_pixel_packer #(
		.SPRITE_ROWS(ROWS),
		.COLOR_SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.spr(spr),
		.cfg(cfg)
	);

	// encoder state mirrored on the testbench side
	logic [1:0] cur_mode;
	logic [7:0] cur_transparent;
	logic [7:0] cur_multi_one;
	logic [7:0] cur_multi_two;
	logic [2:0] slot;
	logic [7:0] acc;
	logic [8:0] pix_count;
	logic [7:0] colors [SLOTS];
	logic [2:0] colors_used;
	logic       over;

	logic [7:0]          pixels_to_send [$];
	c64spp_pkg::result_t sprite_bytes_due [$];
	c64spp_pkg::result_t want_beat;
	int                  errors = 0;

	logic [7:0] palette [6];
	int         pal_n = 1;
	int         noise_pct = 0;

	function automatic int sprite_length(input logic [1:0] m);
		return (m == c64spp_pkg::MODE_MONO) ? c64spp_pkg::PIX_PER_ROW_MONO * ROWS
			: c64spp_pkg::PIX_PER_ROW_MULTI * ROWS;
	endfunction

	function automatic logic [7:0] pick_reg();
		if ($urandom_range(0, 3) == 0)
			return ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
		return 8'($urandom);
	endfunction

	function automatic logic [7:0] pick_pixel();
		if ($urandom_range(0, 99) < noise_pct)
			return 8'($urandom);
		return palette[3'($urandom_range(0, pal_n - 1))];
	endfunction

	task automatic clear_sprite();
		slot = '0;
		acc = '0;
		pix_count = '0;
		colors_used = '0;
		over = 1'b0;
		for (int i = 0; i < SLOTS; i++)
			colors[i] = '0;
	endtask

	task automatic pack_pixel(input logic [7:0] px);
		logic [1:0]          code;
		logic                hit;
		logic                done;
		logic                full;
		c64spp_pkg::result_t r;
		hit = 1'b0;
		code = c64spp_pkg::CODE_TRANSPARENT;
		if (cur_mode == c64spp_pkg::MODE_MONO) begin
			code = (px != cur_transparent) ? 2'd1 : 2'd0;
			acc = {acc[6:0], code[0]};
		end else begin
			if (cur_mode == c64spp_pkg::MODE_FIXED) begin
				if (px == cur_transparent)
					code = c64spp_pkg::CODE_TRANSPARENT;
				else if (px == cur_multi_one)
					code = c64spp_pkg::CODE_MULTI_ONE;
				else if (px == cur_multi_two)
					code = c64spp_pkg::CODE_MULTI_TWO;
				else
					code = c64spp_pkg::CODE_OTHER;
			end else begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!hit && i < colors_used && colors[i] == px) begin
						hit = 1'b1;
						code = i[1:0];
					end
				end
				if (!hit) begin
					if (colors_used < SLOTS) begin
						colors[colors_used[1:0]] = px;
						code = colors_used[1:0];
						colors_used = colors_used + 3'd1;
					end else begin
						over = 1'b1;
						code = '0;
					end
				end
			end
			acc = {acc[5:0], code};
		end
		slot = slot + 3'd1;
		pix_count = pix_count + 9'd1;
		done = int'(pix_count) >= sprite_length(cur_mode);
		full = (cur_mode == c64spp_pkg::MODE_MONO) ? (slot == 3'd0)
			: (slot >= c64spp_pkg::PIX_PER_BYTE_MULTI);
		if (full || (done && slot != 3'd0)) begin
			r.sprite_byte = acc;
			r.sprite_end = 1'b0;
			r.too_many_colors = 1'b0;
			sprite_bytes_due.push_back(r);
			acc = '0;
			slot = '0;
		end
		if (done) begin
			r.sprite_byte = (cur_mode == c64spp_pkg::MODE_MONO) ? c64spp_pkg::META_MONO
				: c64spp_pkg::META_MULTI;
			r.sprite_end = 1'b1;
			r.too_many_colors = over;
			sprite_bytes_due.push_back(r);
			clear_sprite();
		end
	endtask

	task automatic send_pixel(input logic [7:0] px);
		pack_pixel(px);
		pixels_to_send.push_back(px);
	endtask

	task automatic drain();
		while (pixels_to_send.size() != 0 || sprite_bytes_due.size() != 0)
			@(posedge clk);
		// a pixel may still be in flight without any result behind it
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [c64spp_pkg::CFG_IDX_W-1:0] idx,
			input logic [c64spp_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			c64spp_pkg::REG_MODE:        cur_mode = val[1:0];
			c64spp_pkg::REG_TRANSPARENT: cur_transparent = val;
			c64spp_pkg::REG_MULTI_ONE:   cur_multi_one = val;
			c64spp_pkg::REG_MULTI_TWO:   cur_multi_two = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [1:0] m, input logic [7:0] t, input logic [7:0] o,
			input logic [7:0] w);
		int first;
		first = $urandom_range(0, 3);
		for (int k = 0; k < 4; k++) begin
			case (c64spp_pkg::CFG_IDX_W'((first + k) % 4))
				c64spp_pkg::REG_MODE:
					write_reg(c64spp_pkg::REG_MODE, {6'($urandom), m});
				c64spp_pkg::REG_TRANSPARENT:
					write_reg(c64spp_pkg::REG_TRANSPARENT, t);
				c64spp_pkg::REG_MULTI_ONE:
					write_reg(c64spp_pkg::REG_MULTI_ONE, o);
				default:
					write_reg(c64spp_pkg::REG_MULTI_TWO, w);
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(c64spp_pkg::CFG_IDX_W'($urandom_range(c64spp_pkg::REG_MULTI_TWO + 1, 255)),
				8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// pixel driver: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			pix_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (pix_valid && pix.ready)
				void'(pixels_to_send.pop_front());
			if (!pix_valid || pix.ready) begin
				if (gap_left > 0 || pixels_to_send.size() == 0) begin
					pix_valid <= 1'b0;
					if (gap_left > 0)
						gap_left = gap_left - 1;
				end else begin
					pix_valid <= 1'b1;
					pix_data <= pixels_to_send[0];
					if (burst_left > 0)
						burst_left = burst_left - 1;
					if (burst_left == 0) begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
						burst_left = $urandom_range(1, 40);
					end
				end
			end
		end
	end

	// result monitor; ready follows a repeating random stall pattern, redrawn whenever stall_pos wraps
	logic [15:0] stall_pat = 16'hFFFF;
	int          stall_pos = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			spr_ready <= 1'b0;
		end else begin
			if (spr.valid && spr_ready) begin
				if (sprite_bytes_due.size() == 0) begin
					$error("unexpected sprite beat: sprite_byte %h sprite_end %b",
						spr.sprite_byte, spr.sprite_end);
					errors++;
				end else begin
					want_beat = sprite_bytes_due.pop_front();
					if (spr.sprite_byte !== want_beat.sprite_byte) begin
						$error("sprite_byte: expected %h, got %h",
							want_beat.sprite_byte, spr.sprite_byte);
						errors++;
					end
					if (spr.sprite_end !== want_beat.sprite_end) begin
						$error("sprite_end: expected %b, got %b",
							want_beat.sprite_end, spr.sprite_end);
						errors++;
					end
					if (spr.too_many_colors !== want_beat.too_many_colors) begin
						$error("too_many_colors: expected %b, got %b",
							want_beat.too_many_colors, spr.too_many_colors);
						errors++;
					end
				end
			end
			stall_pos = stall_pos + 1;
			if (stall_pos == 48) begin
				stall_pos = 0;
				stall_pat = ($urandom_range(0, 2) == 0) ? 16'hFFFF
					: (16'($urandom) | 16'h0001);
			end
			spr_ready <= stall_pat[stall_pos % 16];
		end
	end

	int quiet = 0;

	always @(posedge clk) begin
		if (!arst_n)
			quiet <= 0;
		else if ((pix_valid && pix.ready) || (spr.valid && spr_ready)
				|| (cfg_valid && cfg.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
	end

	initial begin
		while (quiet < QUIET_LIMIT)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		logic [7:0] mono_px [8];
		logic [7:0] fixed_px [6];
		logic [7:0] auto_px [6];
		logic [1:0] m;
		int         sent;
		int         phase;
		int         n;
		mono_px  = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'hFE, 8'h7F};
		fixed_px = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h00, 8'hFF};
		auto_px  = '{8'h10, 8'h20, 8'h30, 8'h10, 8'h40, 8'h50};

		cur_mode = c64spp_pkg::MODE_MONO;
		cur_transparent = 8'd0;
		cur_multi_one = 8'd1;
		cur_multi_two = 8'd2;
		clear_sprite();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration, one mono byte
		foreach (mono_px[i])
			send_pixel(mono_px[i]);
		drain();

		// fixed codes in every position, then a half-filled byte
		set_config(c64spp_pkg::MODE_FIXED, 8'hFF, 8'h00, 8'h80);
		foreach (fixed_px[i])
			send_pixel(fixed_px[i]);
		drain();

		// mode three as auto: four colors fill the table, a fifth overflows
		set_config(MODE_AUTO_ALT, 8'h00, 8'h01, 8'h02);
		foreach (auto_px[i])
			send_pixel(auto_px[i]);
		drain();

		sent = 20;
		phase = 0;
		while (sent < ITEMS) begin
			case ($urandom_range(0, 7))
				0, 1:    m = c64spp_pkg::MODE_MONO;
				2, 3:    m = c64spp_pkg::MODE_FIXED;
				4, 5, 6: m = c64spp_pkg::MODE_AUTO;
				default: m = MODE_AUTO_ALT;
			endcase
			// stop a mono sprite past the multicolor length, then switch: it closes at once
			if (phase == 0)
				m = c64spp_pkg::MODE_MONO;
			if (phase == 1)
				m = c64spp_pkg::MODE_FIXED;
			set_config(m, pick_reg(), pick_reg(), pick_reg());

			pal_n = $urandom_range(1, 6);
			palette[0] = cur_transparent;
			palette[1] = cur_multi_one;
			palette[2] = cur_multi_two;
			for (int i = 3; i < 6; i++)
				palette[i] = 8'($urandom);
			noise_pct = ($urandom_range(0, 1) == 0) ? 0 : 8;

			if (phase == 0)
				n = $urandom_range(260, 500) - int'(pix_count);
			else if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, 60);
			else
				n = sprite_length(cur_mode) - int'(pix_count);
			if (n < 1)
				n = 1;

			for (int i = 0; i < n; i++)
				send_pixel(pick_pixel());
			drain();
			sent += n;
			phase++;
		end

		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
